[hw/rtl/pose_frame_deframer_assert.svh]
// Assertion macros for the pose frame deframer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef POSE_FRAME_DEFRAMER_ASSERT_SVH
`define POSE_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PFD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PFD_ASSERT(label, clk, rst_n, prop, msg)
`define PFD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

[hw/rtl/pfd_pkg.sv]
// Shared types and constants of the pose frame deframer.
// Used by every RTL module of the block; depends on nothing.
package pfd_pkg;

	localparam int PAYLOAD_BYTES = 24;
	localparam int NUM_WORDS     = 6;
	localparam int CNT_W         = 5;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_0 = 2'd0,
		REG_HEADER_1 = 2'd1,
		REG_TAIL_0   = 2'd2,
		REG_TAIL_1   = 2'd3
	} cfg_index_t;

	typedef enum logic [4:0] {
		PH_HEAD0 = 5'b00001,
		PH_HEAD1 = 5'b00010,
		PH_DATA  = 5'b00100,
		PH_TAIL0 = 5'b01000,
		PH_TAIL1 = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] header_0;
		logic [7:0] header_1;
		logic [7:0] tail_0;
		logic [7:0] tail_1;
	} cfg_t;

	typedef struct packed {
		logic [31:0] yaw;
		logic [31:0] pitch;
		logic [31:0] roll;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] rate;
	} pose_t;

endpackage

[hw/rtl/pfd_cfg_regs.sv]
// Configuration registers holding the expected header and tail bytes.
// Depends on pfd_pkg for the register index codes and the cfg_t struct.
module pfd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output pfd_pkg::cfg_t                 cfg
);

	pfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_0 <= 8'd13;
			cfg_q.header_1 <= 8'd10;
			cfg_q.tail_0   <= 8'd10;
			cfg_q.tail_1   <= 8'd13;
		end else if (cfg_we) begin
			unique case (pfd_pkg::cfg_index_t'(cfg_index))
				pfd_pkg::REG_HEADER_0: cfg_q.header_0 <= cfg_data;
				pfd_pkg::REG_HEADER_1: cfg_q.header_1 <= cfg_data;
				pfd_pkg::REG_TAIL_0:   cfg_q.tail_0   <= cfg_data;
				pfd_pkg::REG_TAIL_1:   cfg_q.tail_1   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/pfd_parser.sv]
// Frame state machine and payload shift line of the pose frame deframer.
// Depends on pfd_pkg and on the assertion macros in pose_frame_deframer_assert.svh.
`include "pose_frame_deframer_assert.svh"

module pfd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  pfd_pkg::cfg_t  cfg,
	input  logic           byte_valid,
	input  logic [7:0]     byte_data,
	input  logic           slot_busy,
	output logic           take,
	output logic           emit,
	output pfd_pkg::pose_t pose
);

	pfd_pkg::phase_t                phase_q;
	pfd_pkg::phase_t                phase_d;
	logic [pfd_pkg::CNT_W-1:0]      count_q;
	logic [pfd_pkg::CNT_W-1:0]      count_d;
	logic [pfd_pkg::CNT_W-1:0]      count_inc;
	logic                           store_en;
	logic                           frame_hit;
	logic [7:0]                     store_q [pfd_pkg::PAYLOAD_BYTES];
	logic [pfd_pkg::NUM_WORDS*32-1:0] words;

	localparam logic [pfd_pkg::CNT_W-1:0] FULL = pfd_pkg::CNT_W'(pfd_pkg::PAYLOAD_BYTES);

	// A completed frame needs a free result slot; every other byte goes through.
	assign frame_hit = (phase_q == pfd_pkg::PH_TAIL1) && (byte_data == cfg.tail_1);
	assign take      = byte_valid && !(frame_hit && slot_busy);
	assign emit      = take && frame_hit;
	assign count_inc = count_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		store_en = 1'b0;
		unique case (phase_q)
			pfd_pkg::PH_HEAD0: begin
				if (byte_data == cfg.header_0) phase_d = pfd_pkg::PH_HEAD1;
			end
			pfd_pkg::PH_HEAD1: begin
				if (byte_data == cfg.header_1) begin
					phase_d = pfd_pkg::PH_DATA;
					count_d = '0;
				end else begin
					phase_d = pfd_pkg::PH_HEAD0;
				end
			end
			pfd_pkg::PH_DATA: begin
				if (count_q < FULL) begin
					store_en = 1'b1;
					count_d  = count_inc;
				end
				if (count_d >= FULL) phase_d = pfd_pkg::PH_TAIL0;
			end
			pfd_pkg::PH_TAIL0: begin
				phase_d = (byte_data == cfg.tail_0) ? pfd_pkg::PH_TAIL1 : pfd_pkg::PH_HEAD0;
			end
			pfd_pkg::PH_TAIL1: begin
				phase_d = pfd_pkg::PH_HEAD0;
			end
			default: phase_d = pfd_pkg::PH_HEAD0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfd_pkg::PH_HEAD0;
			count_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// Each frame shifts in exactly one full payload, so the oldest byte ends up in entry zero.
	always_ff @(posedge clk) begin
		if (take && store_en) begin
			for (int i = 0; i < pfd_pkg::PAYLOAD_BYTES - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[pfd_pkg::PAYLOAD_BYTES-1] <= byte_data;
		end
	end

	always_comb begin
		for (int w = 0; w < pfd_pkg::NUM_WORDS; w++) begin
			words[w*32 +: 32] = {store_q[4*w+3], store_q[4*w+2], store_q[4*w+1], store_q[4*w]};
		end
	end

	assign pose.yaw   = words[0*32 +: 32];
	assign pose.pitch = words[1*32 +: 32];
	assign pose.roll  = words[2*32 +: 32];
	assign pose.pos_x = words[3*32 +: 32];
	assign pose.pos_y = words[4*32 +: 32];
	assign pose.rate  = words[5*32 +: 32];

	`PFD_ASSERT(a_emit_full, clk, arst_n, emit |-> (count_q == FULL), "frame emitted with short payload")
	`PFD_ASSERT(a_tail_full, clk, arst_n, (phase_q == pfd_pkg::PH_TAIL0) |-> (count_q == FULL), "tail phase without full payload")
	`PFD_ASSERT_NEXT(a_data_count, clk, arst_n, (take && phase_q == pfd_pkg::PH_DATA), (count_q == pfd_pkg::CNT_W'($past(count_q) + 1'b1)), "payload count did not advance")

endmodule

[hw/rtl/pfd_result_reg.sv]
// Output register that holds one decoded pose until the receiver takes it.
// Depends on pfd_pkg for the pose_t struct.
module pfd_result_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  pfd_pkg::pose_t pose_in,
	input  logic           res_stall,
	output logic           res_valid,
	output pfd_pkg::pose_t pose_out
);

	logic           valid_q;
	pfd_pkg::pose_t pose_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pose_q <= pose_in;
		end
	end

	assign res_valid = valid_q;
	assign pose_out  = pose_q;

endmodule

[hw/rtl/pose_frame_deframer.sv]
// Top level of the pose frame deframer: input register, configuration registers, parser and result register.
// Depends on pfd_pkg, pfd_cfg_regs, pfd_parser and pfd_result_reg.

// The block takes one received serial byte per cycle while the input is not stalled, and delivers
// one pose of six 32-bit words. A byte is held in the input register, the frame state machine
// handles it there, and a good frame loads the result register. Input stalls only when a
// frame-closing byte meets a result that is still held by the receiver.
module pose_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [31:0]                   yaw_bits,
	output logic [31:0]                   pitch_bits,
	output logic [31:0]                   roll_bits,
	output logic [31:0]                   pos_x_bits,
	output logic [31:0]                   pos_y_bits,
	output logic [31:0]                   rate_bits
);

	pfd_pkg::cfg_t  cfg;
	pfd_pkg::pose_t pose;
	pfd_pkg::pose_t pose_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           take;
	logic           emit;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	pfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_valid (valid_s1),
		.byte_data  (byte_s1),
		.slot_busy  (res_valid && res_stall),
		.take       (take),
		.emit       (emit),
		.pose       (pose)
	);

	pfd_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.pose_in   (pose),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.pose_out  (pose_q)
	);

	assign yaw_bits   = pose_q.yaw;
	assign pitch_bits = pose_q.pitch;
	assign roll_bits  = pose_q.roll;
	assign pos_x_bits = pose_q.pos_x;
	assign pos_y_bits = pose_q.pos_y;
	assign rate_bits  = pose_q.rate;

endmodule
